FILE: sv/hbpc_pkg.sv
// ----------------------------------------------------------------------------
// hbpc_pkg
// Shared constants, register codes and the pixel position table of the
// HSV blob pixel colour unit.
// ----------------------------------------------------------------------------
package hbpc_pkg;

    // strip geometry
    localparam int STRIP_LENGTH = 256;
    localparam int POS_DIV      = (STRIP_LENGTH > 1) ? (STRIP_LENGTH - 1) : 1;
    localparam int POS_MAX      = (255 * 65536) / POS_DIV;
    localparam int POS_W        = $clog2(POS_MAX + 1);
    localparam int DIST_W       = (POS_W > 17) ? POS_W : 17;
    localparam bit BLOB_ALLOWED = (STRIP_LENGTH > 1);

    // Q1.16 one and Q0.16 width floor
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [15:0] WIDTH_FLOOR = 16'd655;

    // pipeline layout: entry, distance, divider steps, two weight stages, output
    localparam int DIV_STAGES = 16;
    localparam int NSTG       = DIV_STAGES + 5;
    localparam int ST_W1      = DIV_STAGES + 2;
    localparam int ST_W2      = DIV_STAGES + 3;
    localparam int ST_OUT     = DIV_STAGES + 4;

    // register map
    typedef enum logic [2:0] {
        REG_HUE        = 3'd0,
        REG_SATURATION = 3'd1,
        REG_BRIGHTNESS = 3'd2,
        REG_WHITE      = 3'd3,
        REG_BLOB_EN    = 3'd4,
        REG_CENTER     = 3'd5,
        REG_WIDTH      = 3'd6,
        REG_CUBIC      = 3'd7
    } t_reg_idx;

    // pixel index to strip position, Q1.16
    typedef logic [POS_W-1:0] t_pos_table [256];

    function automatic t_pos_table make_pos_table();
        t_pos_table tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = POS_W'((i * 65536) / POS_DIV);
        end
        return tbl;
    endfunction

    localparam t_pos_table POS_TABLE = make_pos_table();

endpackage

FILE: sv/hsv_blob_pixel_color_unit.sv
// ----------------------------------------------------------------------------
// hsv_blob_pixel_color_unit
// Colour of one LED: HSV to RGB with white lift and radial blob falloff.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  pixel in  i_valid, o_stall, i_pixel_index      request in
//  pixel out o_valid, i_stall, o_pixel_number,
//            o_red, o_green, o_blue               request out
//  config    psel, penable, pwrite, paddr,
//            pwdata, prdata, pready               APB slave
//
//  One request per cycle sustained unless the output stalls; distance over
//  half width is formed by the 16-step restoring divider, one bit a stage.
//  Colour from the registers runs in a free-running 5-stage pipeline.
//  Sync active-low reset clears valid bits and registers; centre 0.5, width 1.0.
//  A stall while o_valid is high freezes the pixel pipeline; o_stall follows it.
// ----------------------------------------------------------------------------
module hsv_blob_pixel_color_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pixel_number,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    logic [15:0] r_hue;
    logic [16:0] r_sat, r_bri, r_white, r_center, r_width;
    logic        r_blob_en, r_cubic;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue     <= '0;
            r_sat     <= '0;
            r_bri     <= '0;
            r_white   <= '0;
            r_blob_en <= 1'b0;
            r_center  <= 17'd32768;
            r_width   <= 17'd65536;
            r_cubic   <= 1'b0;
        end else if (cfg_wr) begin
            case (hbpc_pkg::t_reg_idx'(paddr[4:2]))
                hbpc_pkg::REG_HUE:        r_hue     <= pwdata[15:0];
                hbpc_pkg::REG_SATURATION: r_sat     <= pwdata[16:0];
                hbpc_pkg::REG_BRIGHTNESS: r_bri     <= pwdata[16:0];
                hbpc_pkg::REG_WHITE:      r_white   <= pwdata[16:0];
                hbpc_pkg::REG_BLOB_EN:    r_blob_en <= pwdata[0];
                hbpc_pkg::REG_CENTER:     r_center  <= pwdata[16:0];
                hbpc_pkg::REG_WIDTH:      r_width   <= pwdata[16:0];
                hbpc_pkg::REG_CUBIC:      r_cubic   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (hbpc_pkg::t_reg_idx'(paddr[4:2]))
            hbpc_pkg::REG_HUE:        prdata = {16'd0, r_hue};
            hbpc_pkg::REG_SATURATION: prdata = {15'd0, r_sat};
            hbpc_pkg::REG_BRIGHTNESS: prdata = {15'd0, r_bri};
            hbpc_pkg::REG_WHITE:      prdata = {15'd0, r_white};
            hbpc_pkg::REG_BLOB_EN:    prdata = {31'd0, r_blob_en};
            hbpc_pkg::REG_CENTER:     prdata = {15'd0, r_center};
            hbpc_pkg::REG_WIDTH:      prdata = {15'd0, r_width};
            hbpc_pkg::REG_CUBIC:      prdata = {31'd0, r_cubic};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- colour pipeline (free running) ----------------
    logic [16:0] c_sat, c_bri, c_white, c_center, c_width;
    logic [18:0] h6;
    logic [24:0] wb_prod;

    assign c_sat    = (r_sat    > hbpc_pkg::ONE_Q16) ? hbpc_pkg::ONE_Q16 : r_sat;
    assign c_bri    = (r_bri    > hbpc_pkg::ONE_Q16) ? hbpc_pkg::ONE_Q16 : r_bri;
    assign c_white  = (r_white  > hbpc_pkg::ONE_Q16) ? hbpc_pkg::ONE_Q16 : r_white;
    assign c_center = (r_center > hbpc_pkg::ONE_Q16) ? hbpc_pkg::ONE_Q16 : r_center;
    assign c_width  = (r_width  > hbpc_pkg::ONE_Q16) ? hbpc_pkg::ONE_Q16 : r_width;
    assign h6       = 19'(r_hue) * 19'd6;
    assign wb_prod  = 25'(c_white) * 25'd255;

    // stage 1: clamps, sector split, white byte, half width
    logic [16:0] r_c1_s, r_c1_v;
    logic [2:0]  r_c1_sec;
    logic [15:0] r_c1_f;
    logic [7:0]  r_c1_wb;
    logic [15:0] r_half;

    always_ff @(posedge i_clk) begin
        r_c1_s   <= c_sat;
        r_c1_v   <= c_bri;
        r_c1_sec <= h6[18:16];
        r_c1_f   <= h6[15:0];
        r_c1_wb  <= wb_prod[23:16];
        r_half   <= (c_width < 17'(hbpc_pkg::WIDTH_FLOOR)) ? hbpc_pkg::WIDTH_FLOOR
                                                           : c_width[16:1];
    end

    // stage 2: s*f, s*(1-f), p, white lift amount
    logic [33:0] sf_prod, sif_prod, p_prod;
    logic [15:0] w3_prod;

    assign sf_prod  = 34'(r_c1_s) * 34'(r_c1_f);
    assign sif_prod = 34'(r_c1_s) * 34'(hbpc_pkg::ONE_Q16 - 17'(r_c1_f));
    assign p_prod   = 34'(r_c1_v) * 34'(hbpc_pkg::ONE_Q16 - r_c1_s);
    assign w3_prod  = 16'(r_c1_wb) * 16'd171;   // x/3 exact for bytes

    logic [16:0] r_c2_sf, r_c2_sif, r_c2_p, r_c2_v;
    logic [2:0]  r_c2_sec;
    logic [6:0]  r_c2_w;

    always_ff @(posedge i_clk) begin
        r_c2_sf  <= sf_prod[32:16];
        r_c2_sif <= sif_prod[32:16];
        r_c2_p   <= p_prod[32:16];
        r_c2_v   <= r_c1_v;
        r_c2_sec <= r_c1_sec;
        r_c2_w   <= w3_prod[15:9];
    end

    // stage 3: q and t
    logic [33:0] q_prod, t_prod;

    assign q_prod = 34'(r_c2_v) * 34'(hbpc_pkg::ONE_Q16 - r_c2_sf);
    assign t_prod = 34'(r_c2_v) * 34'(hbpc_pkg::ONE_Q16 - r_c2_sif);

    logic [16:0] r_c3_q, r_c3_t, r_c3_p, r_c3_v;
    logic [2:0]  r_c3_sec;
    logic [6:0]  r_c3_w;

    always_ff @(posedge i_clk) begin
        r_c3_q   <= q_prod[32:16];
        r_c3_t   <= t_prod[32:16];
        r_c3_p   <= r_c2_p;
        r_c3_v   <= r_c2_v;
        r_c3_sec <= r_c2_sec;
        r_c3_w   <= r_c2_w;
    end

    // stage 4: sector select and byte conversion
    logic [16:0] rf, gf, bf;
    logic [24:0] rb_prod, gb_prod, bb_prod;

    always_comb begin
        case (r_c3_sec)
            3'd0:    begin rf = r_c3_v; gf = r_c3_t; bf = r_c3_p; end
            3'd1:    begin rf = r_c3_q; gf = r_c3_v; bf = r_c3_p; end
            3'd2:    begin rf = r_c3_p; gf = r_c3_v; bf = r_c3_t; end
            3'd3:    begin rf = r_c3_p; gf = r_c3_q; bf = r_c3_v; end
            3'd4:    begin rf = r_c3_t; gf = r_c3_p; bf = r_c3_v; end
            default: begin rf = r_c3_v; gf = r_c3_p; bf = r_c3_q; end
        endcase
    end

    assign rb_prod = 25'(rf) * 25'd255;
    assign gb_prod = 25'(gf) * 25'd255;
    assign bb_prod = 25'(bf) * 25'd255;

    logic [7:0] r_c4_r, r_c4_g, r_c4_b;
    logic [6:0] r_c4_w;

    always_ff @(posedge i_clk) begin
        r_c4_r <= rb_prod[23:16];
        r_c4_g <= gb_prod[23:16];
        r_c4_b <= bb_prod[23:16];
        r_c4_w <= r_c3_w;
    end

    // stage 5: saturating white lift
    function automatic logic [7:0] lift(input logic [7:0] c, input logic [6:0] w);
        logic [7:0] room;
        room = 8'd255 - c;
        return c + ((room < 8'(w)) ? room : 8'(w));
    endfunction

    logic [7:0] r_col_r, r_col_g, r_col_b;

    always_ff @(posedge i_clk) begin
        r_col_r <= lift(r_c4_r, r_c4_w);
        r_col_g <= lift(r_c4_g, r_c4_w);
        r_col_b <= lift(r_c4_b, r_c4_w);
    end

    // ---------------- pixel pipeline ----------------
    logic adv;
    logic r_vld [hbpc_pkg::NSTG];
    logic [7:0] r_idx [hbpc_pkg::NSTG];
    logic r_ovr [hbpc_pkg::NSTG];

    assign adv     = !r_vld[hbpc_pkg::ST_OUT] || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_vld[hbpc_pkg::ST_OUT];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hbpc_pkg::NSTG; k++) r_vld[k] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < hbpc_pkg::NSTG; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // index and out-of-range flag travel along
    logic [hbpc_pkg::DIST_W-1:0] dist_abs;
    logic over;
    logic [hbpc_pkg::POS_W-1:0] r_pos;
    logic [hbpc_pkg::DIST_W-1:0] pos_x, ctr_x;

    assign pos_x    = hbpc_pkg::DIST_W'(r_pos);
    assign ctr_x    = hbpc_pkg::DIST_W'(c_center);
    assign dist_abs = (pos_x >= ctr_x) ? (pos_x - ctr_x) : (ctr_x - pos_x);
    assign over     = dist_abs >= hbpc_pkg::DIST_W'(r_half);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_idx[0] <= i_pixel_index;
            r_ovr[0] <= 1'b0;
            r_pos    <= hbpc_pkg::POS_TABLE[i_pixel_index];
            r_idx[1] <= r_idx[0];
            r_ovr[1] <= over;
            for (int k = 2; k < hbpc_pkg::NSTG; k++) begin
                r_idx[k] <= r_idx[k-1];
                r_ovr[k] <= r_ovr[k-1];
            end
        end
    end

    // restoring divider: one quotient bit a stage
    logic [15:0] r_rem [hbpc_pkg::DIV_STAGES+1];
    logic [15:0] r_quo [hbpc_pkg::DIV_STAGES+1];
    logic [15:0] n_rem [hbpc_pkg::DIV_STAGES];
    logic [15:0] n_quo [hbpc_pkg::DIV_STAGES];

    always_comb begin
        for (int j = 0; j < hbpc_pkg::DIV_STAGES; j++) begin
            logic [16:0] rem2;
            rem2 = {r_rem[j], 1'b0};
            if (rem2 >= {1'b0, r_half}) begin
                n_rem[j] = 16'(rem2 - {1'b0, r_half});
                n_quo[j] = {r_quo[j][14:0], 1'b1};
            end else begin
                n_rem[j] = rem2[15:0];
                n_quo[j] = {r_quo[j][14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem[0] <= dist_abs[15:0];
            r_quo[0] <= '0;
            for (int j = 0; j < hbpc_pkg::DIV_STAGES; j++) begin
                r_rem[j+1] <= n_rem[j];
                r_quo[j+1] <= n_quo[j];
            end
        end
    end

    // falloff weight: square, then optional cube
    logic [16:0] g_val;
    logic [33:0] gg_prod, ggg_prod;
    logic [16:0] r_g, r_w2, r_wt;

    assign g_val    = hbpc_pkg::ONE_Q16 - 17'(r_quo[hbpc_pkg::DIV_STAGES]);
    assign gg_prod  = 34'(g_val) * 34'(g_val);
    assign ggg_prod = 34'(r_w2) * 34'(r_g);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g  <= g_val;
            r_w2 <= gg_prod[32:16];
            if (r_ovr[hbpc_pkg::ST_W1]) r_wt <= '0;
            else if (r_cubic)          r_wt <= ggg_prod[32:16];
            else                       r_wt <= r_w2;
        end
    end

    // output scaling
    logic [24:0] ro_prod, go_prod, bo_prod;
    logic blob_on;

    assign blob_on = r_blob_en && hbpc_pkg::BLOB_ALLOWED;
    assign ro_prod = 25'(r_col_r) * 25'(r_wt);
    assign go_prod = 25'(r_col_g) * 25'(r_wt);
    assign bo_prod = 25'(r_col_b) * 25'(r_wt);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_pixel_number <= r_idx[hbpc_pkg::ST_W2];
            o_red          <= blob_on ? ro_prod[23:16] : r_col_r;
            o_green        <= blob_on ? go_prod[23:16] : r_col_g;
            o_blue         <= blob_on ? bo_prod[23:16] : r_col_b;
        end
    end

endmodule
